// ----- rtl/core/rht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rht_pkg
// Shared types and codes for the region hit tester: action and status
// codes, controller states, datapath operations and control/status bundles.
// ----------------------------------------------------------------------------
package rht_pkg;

  // Action codes carried in each input beat
  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_RECT   = 3'd1,
    ACT_VERTEX = 3'd2,
    ACT_MOVE   = 3'd3,
    ACT_LEAVE  = 3'd4
  } action_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2
  } status_e;

  // Smallest polygon that is kept
  localparam int unsigned MinPolyVerts = 3;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_NEXT,
    S_RCHK,
    S_VPREV,
    S_VCUR,
    S_VCMP,
    S_PEND,
    S_FINISH
  } ctrl_state_e;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_EXEC,
    DP_SINIT,
    DP_RREAD,
    DP_VSTART,
    DP_VPREV,
    DP_VMUL,
    DP_VCMP,
    DP_FOUND,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic       is_move;
    logic       k_zero;
    logic       box_in;
    logic       is_rect;
    logic       edge_done;
    logic       poly_in;
  } dp_stat_t;

endpackage

// ----- rtl/core/rht_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rht_ctrl
// Controller: sequences one item at a time through the datapath and owns
// the input ready and output valid of the stream ports.
// ----------------------------------------------------------------------------
module rht_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  rht_pkg::dp_stat_t stat_i,
  output rht_pkg::dp_cmd_t  cmd_o
);

  rht_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic emit;

  // State and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rht_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = rht_pkg::DP_NOP;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      rht_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = rht_pkg::DP_LOAD;
          state_d  = rht_pkg::S_DISPATCH;
        end
      end
      rht_pkg::S_DISPATCH: begin
        if (stat_i.is_move) begin
          cmd_o.op = rht_pkg::DP_SINIT;
          state_d  = rht_pkg::S_NEXT;
        end else begin
          cmd_o.op = rht_pkg::DP_EXEC;
          state_d  = rht_pkg::S_FINISH;
        end
      end
      rht_pkg::S_NEXT: begin
        if (stat_i.k_zero) begin
          state_d = rht_pkg::S_FINISH;
        end else begin
          cmd_o.op = rht_pkg::DP_RREAD;
          state_d  = rht_pkg::S_RCHK;
        end
      end
      rht_pkg::S_RCHK: begin
        if (!stat_i.box_in) begin
          state_d = rht_pkg::S_NEXT;
        end else if (stat_i.is_rect) begin
          cmd_o.op = rht_pkg::DP_FOUND;
          state_d  = rht_pkg::S_FINISH;
        end else begin
          cmd_o.op = rht_pkg::DP_VSTART;
          state_d  = rht_pkg::S_VPREV;
        end
      end
      rht_pkg::S_VPREV: begin
        cmd_o.op = rht_pkg::DP_VPREV;
        state_d  = rht_pkg::S_VCUR;
      end
      rht_pkg::S_VCUR: begin
        cmd_o.op = rht_pkg::DP_VMUL;
        state_d  = rht_pkg::S_VCMP;
      end
      rht_pkg::S_VCMP: begin
        cmd_o.op = rht_pkg::DP_VCMP;
        state_d  = stat_i.edge_done ? rht_pkg::S_PEND : rht_pkg::S_VCUR;
      end
      rht_pkg::S_PEND: begin
        if (stat_i.poly_in) begin
          cmd_o.op = rht_pkg::DP_FOUND;
          state_d  = rht_pkg::S_FINISH;
        end else begin
          state_d = rht_pkg::S_NEXT;
        end
      end
      rht_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = rht_pkg::DP_EMIT;
          emit     = 1'b1;
          state_d  = rht_pkg::S_IDLE;
        end
      end
      default: state_d = rht_pkg::S_IDLE;
    endcase
  end

  // Hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_ready_i))
    else $error("result emitted over an untaken beat");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == rht_pkg::S_DISPATCH))
    else $error("accepted beat not dispatched");

  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rht_pkg::S_IDLE) |-> (cmd_o.op != rht_pkg::DP_EMIT))
    else $error("emit outside finish");

endmodule

// ----- rtl/core/rht_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rht_dp
// Datapath: region table and vertex store memories, polygon gathering,
// bounding-box test and a ray-cast test of each polygon edge, one at a time.
// ----------------------------------------------------------------------------
module rht_dp #(
  parameter int unsigned MAX_REGIONS  = 64,
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned ID_BITS      = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        action_i,
  input  logic [15:0]       x_i,
  input  logic [15:0]       y_i,
  input  logic [14:0]       width_i,
  input  logic [14:0]       height_i,
  input  logic [15:0]       region_id_i,
  input  logic              last_vertex_i,
  input  rht_pkg::dp_cmd_t  cmd_i,
  output rht_pkg::dp_stat_t stat_o,
  output logic              hit_o,
  output logic [15:0]       hit_id_o,
  output logic              hover_changed_o,
  output logic [1:0]        status_o
);

  localparam int unsigned RAW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned RCW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned VAW = $clog2(MAX_VERTICES);
  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned IDW = (ID_BITS < 16) ? ID_BITS : 16;

  // Item capture
  logic [2:0]         act_q;
  logic signed [15:0] px_q, py_q;
  logic [14:0]        w_q, h_q;
  logic [IDW-1:0]     id_q;
  logic               last_q;

  // Control-side state
  logic [RCW-1:0] total_q;
  logic [VCW-1:0] fill_q, pcnt_q;
  logic [63:0]    pbox_q;
  logic           hover_valid_q;
  logic [IDW-1:0] hover_id_q;
  logic [RCW-1:0] k_q;
  logic [VCW-1:0] i_q;
  logic           inside_q;

  // Result holding
  logic           res_hit_q;
  logic [IDW-1:0] res_id_q;
  logic [1:0]     res_status_q;

  // Memories
  logic [63:0]     rbox_mem  [MAX_REGIONS];
  logic [IDW-1:0]  rid_mem   [MAX_REGIONS];
  logic [VAW-1:0]  rstart_mem[MAX_REGIONS];
  logic [VCW-1:0]  rcnt_mem  [MAX_REGIONS];
  logic [31:0]     vstore    [MAX_VERTICES];
  logic [63:0]     rbox_rd_q;
  logic [IDW-1:0]  rid_rd_q;
  logic [VAW-1:0]  rstart_rd_q;
  logic [VCW-1:0]  rcnt_rd_q;
  logic [31:0]     vrd_q;

  // Edge pipeline
  logic signed [15:0] bx_q, by_q;
  logic signed [33:0] lhs_q, rhs_q;
  logic               dpos_q, cross_q;

  // Execute-step logic
  logic [VCW:0]       slot;
  logic               slot_full;
  logic [63:0]        vbox;
  logic [VCW-1:0]     pcnt_inc;
  logic signed [17:0] xe, ye;
  logic signed [15:0] x1s, y1s;
  logic               reg_we, vtx_we;
  logic [63:0]        wbox;
  logic [VAW-1:0]     wstart;
  logic [VCW-1:0]     wcnt;
  logic               commit_ok;
  logic [1:0]         exec_status;

  always_comb begin
    slot      = {1'b0, fill_q} + {1'b0, pcnt_q};
    slot_full = (slot >= (VCW + 1)'(MAX_VERTICES));
    pcnt_inc  = pcnt_q + 1'b1;
    if (pcnt_q == '0) begin
      vbox = {px_q, py_q, px_q, py_q};
    end else begin
      vbox[63:48] = ($signed(px_q) < $signed(pbox_q[63:48])) ? px_q : pbox_q[63:48];
      vbox[47:32] = ($signed(py_q) < $signed(pbox_q[47:32])) ? py_q : pbox_q[47:32];
      vbox[31:16] = ($signed(px_q) > $signed(pbox_q[31:16])) ? px_q : pbox_q[31:16];
      vbox[15:0]  = ($signed(py_q) > $signed(pbox_q[15:0]))  ? py_q : pbox_q[15:0];
    end
    // Saturate the rectangle far edges
    xe  = 18'(px_q) + $signed({3'b000, w_q});
    ye  = 18'(py_q) + $signed({3'b000, h_q});
    x1s = (xe > 18'sd32767) ? 16'sh7fff : xe[15:0];
    y1s = (ye > 18'sd32767) ? 16'sh7fff : ye[15:0];

    commit_ok   = (total_q < RCW'(MAX_REGIONS));
    reg_we      = 1'b0;
    vtx_we      = 1'b0;
    wbox        = {px_q, py_q, x1s, y1s};
    wstart      = '0;
    wcnt        = '0;
    exec_status = rht_pkg::ST_OK;
    if (cmd_i.op == rht_pkg::DP_EXEC) begin
      case (act_q)
        rht_pkg::ACT_RECT: begin
          if (commit_ok) reg_we = 1'b1;
          else exec_status = rht_pkg::ST_FULL;
        end
        rht_pkg::ACT_VERTEX: begin
          if (slot_full) begin
            exec_status = rht_pkg::ST_FULL;
          end else begin
            vtx_we = 1'b1;
            if (last_q) begin
              if (pcnt_inc < VCW'(rht_pkg::MinPolyVerts)) begin
                exec_status = rht_pkg::ST_SHORT;
              end else if (!commit_ok) begin
                exec_status = rht_pkg::ST_FULL;
              end else begin
                reg_we = 1'b1;
                wbox   = vbox;
                wstart = fill_q[VAW-1:0];
                wcnt   = pcnt_inc;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  logic [RAW-1:0] k_rd;
  logic [RCW-1:0] k_dec;
  assign k_dec = k_q - 1'b1;
  assign k_rd  = k_dec[RAW-1:0];

  // Region table write and read
  always_ff @(posedge clk_i) begin
    if (reg_we) begin
      rbox_mem[total_q[RAW-1:0]]   <= wbox;
      rid_mem[total_q[RAW-1:0]]    <= id_q;
      rstart_mem[total_q[RAW-1:0]] <= wstart;
      rcnt_mem[total_q[RAW-1:0]]   <= wcnt;
    end
    if (cmd_i.op == rht_pkg::DP_RREAD) begin
      rbox_rd_q   <= rbox_mem[k_rd];
      rid_rd_q    <= rid_mem[k_rd];
      rstart_rd_q <= rstart_mem[k_rd];
      rcnt_rd_q   <= rcnt_mem[k_rd];
    end
  end

  // Vertex store write and read
  logic [VCW:0]   vaddr_w;
  logic [VAW-1:0] vaddr;
  always_comb begin
    if (cmd_i.op == rht_pkg::DP_VSTART) begin
      vaddr_w = {1'b0, VCW'(rstart_rd_q)} + {1'b0, rcnt_rd_q} - 1'b1;
    end else begin
      vaddr_w = {1'b0, VCW'(rstart_rd_q)} + {1'b0, i_q};
    end
    vaddr = vaddr_w[VAW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (vtx_we) begin
      vstore[slot[VAW-1:0]] <= {px_q, py_q};
    end
    if (cmd_i.op == rht_pkg::DP_VSTART || cmd_i.op == rht_pkg::DP_VPREV ||
        cmd_i.op == rht_pkg::DP_VCMP) begin
      vrd_q <= vstore[vaddr];
    end
  end

  // Edge products
  logic signed [15:0] ax, ay;
  logic signed [16:0] dxp, dd, dxb, dyp;
  assign ax  = vrd_q[31:16];
  assign ay  = vrd_q[15:0];
  assign dxp = 17'(px_q) - 17'(ax);
  assign dd  = 17'(by_q) - 17'(ay);
  assign dxb = 17'(bx_q) - 17'(ax);
  assign dyp = 17'(py_q) - 17'(ay);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rht_pkg::DP_VPREV) begin
      bx_q <= ax;
      by_q <= ay;
    end else if (cmd_i.op == rht_pkg::DP_VMUL) begin
      lhs_q   <= dxp * dd;
      rhs_q   <= dxb * dyp;
      dpos_q  <= (dd > 17'sd0);
      cross_q <= ((ay > py_q) != (by_q > py_q));
      bx_q    <= ax;
      by_q    <= ay;
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rht_pkg::DP_LOAD) begin
      act_q  <= action_i;
      px_q   <= x_i;
      py_q   <= y_i;
      w_q    <= width_i;
      h_q    <= height_i;
      id_q   <= region_id_i[IDW-1:0];
      last_q <= last_vertex_i;
    end
  end

  logic hov_chg;
  always_comb begin
    hov_chg = 1'b0;
    if (act_q == rht_pkg::ACT_MOVE) begin
      hov_chg = (hover_valid_q != res_hit_q) || (res_hit_q && hover_id_q != res_id_q);
    end else if (act_q == rht_pkg::ACT_LEAVE) begin
      hov_chg = hover_valid_q;
    end
  end

  // Control registers: counters, pending polygon, hover, search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q       <= '0;
      fill_q        <= '0;
      pcnt_q        <= '0;
      pbox_q        <= '0;
      hover_valid_q <= 1'b0;
      hover_id_q    <= '0;
      k_q           <= '0;
      i_q           <= '0;
      inside_q      <= 1'b0;
      res_hit_q     <= 1'b0;
      res_id_q      <= '0;
      res_status_q  <= '0;
    end else begin
      case (cmd_i.op)
        rht_pkg::DP_LOAD: begin
          res_hit_q    <= 1'b0;
          res_id_q     <= '0;
          res_status_q <= rht_pkg::ST_OK;
        end
        rht_pkg::DP_EXEC: begin
          res_status_q <= exec_status;
          if (reg_we) total_q <= total_q + 1'b1;
          if (act_q == rht_pkg::ACT_CLEAR) begin
            total_q <= '0;
            fill_q  <= '0;
            pcnt_q  <= '0;
            pbox_q  <= '0;
          end else if (act_q == rht_pkg::ACT_VERTEX) begin
            if (slot_full || last_q) begin
              pcnt_q <= '0;
              pbox_q <= '0;
            end else begin
              pcnt_q <= pcnt_inc;
              pbox_q <= vbox;
            end
            if (reg_we) fill_q <= fill_q + pcnt_inc;
          end
        end
        rht_pkg::DP_SINIT: k_q <= total_q;
        rht_pkg::DP_RREAD: k_q <= k_dec;
        rht_pkg::DP_VSTART: begin
          i_q      <= '0;
          inside_q <= 1'b0;
        end
        rht_pkg::DP_VMUL: i_q <= i_q + 1'b1;
        rht_pkg::DP_VCMP: begin
          if (cross_q && (dpos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q))) begin
            inside_q <= !inside_q;
          end
        end
        rht_pkg::DP_FOUND: begin
          res_hit_q <= 1'b1;
          res_id_q  <= rid_rd_q;
        end
        rht_pkg::DP_EMIT: begin
          if (act_q == rht_pkg::ACT_MOVE) begin
            hover_valid_q <= res_hit_q;
            hover_id_q    <= res_hit_q ? res_id_q : '0;
          end else if (act_q == rht_pkg::ACT_LEAVE) begin
            hover_valid_q <= 1'b0;
            hover_id_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rht_pkg::DP_EMIT) begin
      hit_o           <= res_hit_q;
      hit_id_o        <= 16'(res_id_q);
      hover_changed_o <= hov_chg;
      status_o        <= res_status_q;
    end
  end

  // Status to controller
  always_comb begin
    stat_o.is_move   = (act_q == rht_pkg::ACT_MOVE);
    stat_o.k_zero    = (k_q == '0);
    stat_o.box_in    = ($signed(px_q) >= $signed(rbox_rd_q[63:48])) &&
                       ($signed(px_q) <= $signed(rbox_rd_q[31:16])) &&
                       ($signed(py_q) >= $signed(rbox_rd_q[47:32])) &&
                       ($signed(py_q) <= $signed(rbox_rd_q[15:0]));
    stat_o.is_rect   = (rcnt_rd_q == '0);
    stat_o.edge_done = (i_q == rcnt_rd_q);
    stat_o.poly_in   = inside_q;
  end

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= RCW'(MAX_REGIONS))
    else $error("region count past table size");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, fill_q} + {1'b0, pcnt_q}) <= (VCW + 1)'(MAX_VERTICES))
    else $error("vertex fill past store size");

  a_hover_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hover_valid_q |-> (hover_id_q == '0))
    else $error("hover id kept without hover");

endmodule

// ----- rtl/core/region_hit_tester_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_hit_tester_core
// Clear, add rectangle and vertex beats go from dispatch to finish; a pointer
// move walks the regions from the newest down, checks each bounding box and
// runs a ray-cast edge test over each polygon whose box holds the point.
// Throughput: one item at a time; the next beat is taken once a result sits
// in the output register. Reset clears counters, hover and handshake state;
// the region table and vertex store need no clearing pass.
// ----------------------------------------------------------------------------
module region_hit_tester_core #(
  parameter int unsigned MAX_REGIONS  = 64,
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned ID_BITS      = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // action[2:0], x[18:3], y[34:19], width[49:35], height[64:50],
  // region_id[80:65], zero pad[87:81]
  input  logic [87:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,   // last_vertex
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // hit[0], hit_id[16:1], hover_changed[17], status[19:18], zero pad[23:20]
  output logic [23:0] m_axis_tdata_o
);

  rht_pkg::dp_cmd_t  cmd;
  rht_pkg::dp_stat_t stat;
  logic              hit;
  logic [15:0]       hit_id;
  logic              hover_changed;
  logic [1:0]        status;

  rht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rht_dp #(
    .MAX_REGIONS  (MAX_REGIONS),
    .MAX_VERTICES (MAX_VERTICES),
    .ID_BITS      (ID_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (s_axis_tdata_i[2:0]),
    .x_i             (s_axis_tdata_i[18:3]),
    .y_i             (s_axis_tdata_i[34:19]),
    .width_i         (s_axis_tdata_i[49:35]),
    .height_i        (s_axis_tdata_i[64:50]),
    .region_id_i     (s_axis_tdata_i[80:65]),
    .last_vertex_i   (s_axis_tlast_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .hit_o           (hit),
    .hit_id_o        (hit_id),
    .hover_changed_o (hover_changed),
    .status_o        (status)
  );

  assign m_axis_tdata_o = {4'b0000, status, hover_changed, hit_id, hit};

endmodule
